[rtl/core/tfrc_pkg.sv]
package tfrc_pkg;

    localparam int ENTRIES_DEFAULT = 16;
    localparam logic [4:0] CAPACITY_RESET = 5'd10;

    localparam logic [2:0] ST_MISS    = 3'd0;
    localparam logic [2:0] ST_HIT     = 3'd1;
    localparam logic [2:0] ST_STORED  = 3'd2;
    localparam logic [2:0] ST_RENEWED = 3'd3;
    localparam logic [2:0] ST_IGNORED = 3'd4;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TRIM,
        S_AGE_RD,
        S_AGE_CHK,
        S_DROP,
        S_DECIDE,
        S_EVICT,
        S_WRITE,
        S_PAY_RD,
        S_PAY_WAIT,
        S_OUT
    } state_t;

endpackage

[rtl/core/tfrc_ram.sv]
module tfrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/core/ttl_fifo_record_cache_top.sv]
// Each word passes through the trim state, then each entry is read, aged and matched in turn,
// then the block decides; a dropped last entry, an eviction, the new entry's write or the
// payload reads may follow before out_valid. A zero TTL insert goes from the trim state
// straight to the result as ignored. Each entry trimmed after a capacity drop adds a further
// pass through the trim state. One word at a time; the next word is taken after the result leaves.
// Reset: asynchronous, active low; clears valid bits, live count and time, capacity to 10.
module ttl_fifo_record_cache_top #(
    parameter int ENTRIES = tfrc_pkg::ENTRIES_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [4:0]   cfg_data,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic         opcode,
    input  logic [31:0]  now_seconds,
    input  logic [63:0]  name_key,
    input  logic [15:0]  record_type,
    input  logic [15:0]  record_class,
    input  logic [30:0]  ttl_in,
    input  logic [63:0]  rdata_high,
    input  logic [63:0]  rdata_low,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [2:0]   status,
    output logic [30:0]  ttl_out,
    output logic [63:0]  rdata_high_out,
    output logic [63:0]  rdata_low_out,
    output logic [4:0]   entry_count
);

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int KW = 64 + 16 + 16;

    tfrc_pkg::state_t state_reg, state_next;

    logic [4:0]         capacity_reg;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [AW-1:0]      rank_reg [ENTRIES];
    logic [AW-1:0]      rank_next [ENTRIES];
    logic [CW-1:0]      live_reg, live_next;
    logic [31:0]        last_reg, last_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic               hit_reg, hit_next;
    logic [AW-1:0]      hit_idx_reg, hit_idx_next;
    logic [30:0]        hit_ttl_reg, hit_ttl_next;
    logic [2:0]         status_reg, status_next;
    logic [30:0]        ttl_out_reg, ttl_out_next;
    logic [63:0]        hi_out_reg, hi_out_next, lo_out_reg, lo_out_next;

    logic               op_reg;
    logic [31:0]        now_reg;
    logic [KW-1:0]      key_reg;
    logic [30:0]        ttl_reg;
    logic [63:0]        hi_reg, lo_reg;

    logic               km_we, tt_we, pl_we;
    logic [AW-1:0]      km_waddr, tt_waddr, rd_addr;
    logic [KW-1:0]      km_rdata;
    logic [30:0]        tt_wdata, tt_rdata;
    logic [AW:0]        pl_waddr, pl_raddr;
    logic [63:0]        pl_wdata, pl_rdata;

    logic [CW-1:0]      cap;
    logic [31:0]        elapsed;
    logic               last_idx;
    logic [AW-1:0]      oldest, free_idx;
    logic               drop_en;
    logic [AW-1:0]      drop_idx;

    tfrc_ram #(.WIDTH(KW), .DEPTH(ENTRIES)) u_key_ram (
        .clk(clk), .we(km_we), .waddr(km_waddr), .wdata(key_reg),
        .raddr(rd_addr), .rdata(km_rdata));

    tfrc_ram #(.WIDTH(31), .DEPTH(ENTRIES)) u_ttl_ram (
        .clk(clk), .we(tt_we), .waddr(tt_waddr), .wdata(tt_wdata),
        .raddr(rd_addr), .rdata(tt_rdata));

    tfrc_ram #(.WIDTH(64), .DEPTH(2 * ENTRIES)) u_pay_ram (
        .clk(clk), .we(pl_we), .waddr(pl_waddr), .wdata(pl_wdata),
        .raddr(pl_raddr), .rdata(pl_rdata));

    always_comb
    begin
        if (capacity_reg == 5'd0)
        begin
            cap = CW'(1);
        end
        else if (32'(capacity_reg) > ENTRIES)
        begin
            cap = CW'(ENTRIES);
        end
        else
        begin
            cap = CW'(capacity_reg);
        end
    end

    assign elapsed  = now_reg - last_reg;
    assign last_idx = (32'(idx_reg) == ENTRIES - 1);

    always_comb
    begin
        oldest   = '0;
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && rank_reg[i] == '0)
            begin
                oldest = AW'(i);
            end
            if (!valid_reg[i])
            begin
                free_idx = AW'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= tfrc_pkg::S_IDLE;
            capacity_reg <= tfrc_pkg::CAPACITY_RESET;
            valid_reg    <= '0;
            live_reg     <= '0;
            last_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            live_reg  <= live_next;
            last_reg  <= last_next;
            if (cfg_valid && cfg_ready)
            begin
                capacity_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rank_reg    <= rank_next;
        idx_reg     <= idx_next;
        hit_reg     <= hit_next;
        hit_idx_reg <= hit_idx_next;
        hit_ttl_reg <= hit_ttl_next;
        status_reg  <= status_next;
        ttl_out_reg <= ttl_out_next;
        hi_out_reg  <= hi_out_next;
        lo_out_reg  <= lo_out_next;
        if (in_valid && in_ready)
        begin
            op_reg  <= opcode;
            now_reg <= now_seconds;
            key_reg <= {name_key, record_type, record_class};
            ttl_reg <= ttl_in;
            hi_reg  <= rdata_high;
            lo_reg  <= rdata_low;
        end
    end

    assign cfg_ready      = (state_reg == tfrc_pkg::S_IDLE);
    assign in_ready       = (state_reg == tfrc_pkg::S_IDLE);
    assign out_valid      = (state_reg == tfrc_pkg::S_OUT);
    assign status         = status_reg;
    assign ttl_out        = ttl_out_reg;
    assign rdata_high_out = hi_out_reg;
    assign rdata_low_out  = lo_out_reg;
    assign entry_count    = 5'(live_reg);

    always_comb
    begin
        state_next   = state_reg;
        valid_next   = valid_reg;
        rank_next    = rank_reg;
        live_next    = live_reg;
        last_next    = last_reg;
        idx_next     = idx_reg;
        hit_next     = hit_reg;
        hit_idx_next = hit_idx_reg;
        hit_ttl_next = hit_ttl_reg;
        status_next  = status_reg;
        ttl_out_next = ttl_out_reg;
        hi_out_next  = hi_out_reg;
        lo_out_next  = lo_out_reg;
        km_we        = 1'b0;
        km_waddr     = idx_reg;
        tt_we        = 1'b0;
        tt_waddr     = idx_reg;
        tt_wdata     = ttl_reg;
        pl_we        = 1'b0;
        pl_waddr     = {idx_reg, 1'b0};
        pl_wdata     = hi_reg;
        pl_raddr     = {hit_idx_reg, 1'b0};
        rd_addr      = idx_reg;
        drop_en      = 1'b0;
        drop_idx     = oldest;

        case (state_reg)
            tfrc_pkg::S_IDLE:
            begin
                idx_next     = '0;
                hit_next     = 1'b0;
                status_next  = tfrc_pkg::ST_MISS;
                ttl_out_next = '0;
                hi_out_next  = '0;
                lo_out_next  = '0;
                if (in_valid)
                begin
                    state_next = tfrc_pkg::S_TRIM;
                end
            end
            tfrc_pkg::S_TRIM:
            begin
                rd_addr = '0;
                if (live_reg > cap)
                begin
                    drop_en = 1'b1;
                end
                else if (op_reg == tfrc_pkg::OP_INSERT && ttl_reg == '0)
                begin
                    status_next = tfrc_pkg::ST_IGNORED;
                    state_next  = tfrc_pkg::S_OUT;
                end
                else
                begin
                    state_next = tfrc_pkg::S_AGE_CHK;
                end
            end
            tfrc_pkg::S_AGE_RD:
            begin
                state_next = tfrc_pkg::S_AGE_CHK;
            end
            tfrc_pkg::S_AGE_CHK:
            begin
                state_next = tfrc_pkg::S_AGE_RD;
                rd_addr    = idx_reg + AW'(1);
                if (valid_reg[idx_reg])
                begin
                    if (32'(tt_rdata) <= elapsed)
                    begin
                        drop_en    = 1'b1;
                        drop_idx   = idx_reg;
                        state_next = tfrc_pkg::S_DROP;
                    end
                    else
                    begin
                        tt_we    = 1'b1;
                        tt_wdata = 31'(32'(tt_rdata) - elapsed);
                        if (km_rdata == key_reg &&
                            (!hit_reg || rank_reg[idx_reg] < rank_reg[hit_idx_reg]))
                        begin
                            hit_next     = 1'b1;
                            hit_idx_next = idx_reg;
                            hit_ttl_next = tt_wdata;
                        end
                    end
                end
                if (state_next == tfrc_pkg::S_AGE_RD)
                begin
                    idx_next = idx_reg + AW'(1);
                    if (last_idx)
                    begin
                        state_next = tfrc_pkg::S_DECIDE;
                    end
                end
            end
            tfrc_pkg::S_DROP:
            begin
                rd_addr  = idx_reg + AW'(1);
                idx_next = idx_reg + AW'(1);
                state_next = last_idx ? tfrc_pkg::S_DECIDE : tfrc_pkg::S_AGE_CHK;
            end
            tfrc_pkg::S_DECIDE:
            begin
                last_next = now_reg;
                if (op_reg == tfrc_pkg::OP_LOOKUP)
                begin
                    if (hit_reg)
                    begin
                        status_next  = tfrc_pkg::ST_HIT;
                        ttl_out_next = hit_ttl_reg;
                        state_next   = tfrc_pkg::S_PAY_RD;
                    end
                    else
                    begin
                        state_next = tfrc_pkg::S_OUT;
                    end
                end
                else if (hit_reg)
                begin
                    tt_we       = 1'b1;
                    tt_waddr    = hit_idx_reg;
                    tt_wdata    = ttl_reg;
                    status_next = tfrc_pkg::ST_RENEWED;
                    state_next  = tfrc_pkg::S_OUT;
                end
                else
                begin
                    status_next = tfrc_pkg::ST_STORED;
                    state_next  = (live_reg >= cap) ? tfrc_pkg::S_EVICT : tfrc_pkg::S_WRITE;
                end
            end
            tfrc_pkg::S_EVICT:
            begin
                drop_en    = 1'b1;
                state_next = tfrc_pkg::S_WRITE;
            end
            tfrc_pkg::S_WRITE:
            begin
                if (!(&valid_reg))
                begin
                    km_we     = 1'b1;
                    km_waddr  = free_idx;
                    tt_we     = 1'b1;
                    tt_waddr  = free_idx;
                    pl_we     = 1'b1;
                    pl_waddr  = {free_idx, 1'b0};
                    valid_next[free_idx] = 1'b1;
                    rank_next[free_idx]  = AW'(live_reg);
                    live_next = live_reg + CW'(1);
                    idx_next  = free_idx;
                    state_next = tfrc_pkg::S_PAY_WAIT;
                end
                else
                begin
                    state_next = tfrc_pkg::S_OUT;
                end
            end
            tfrc_pkg::S_PAY_RD:
            begin
                hi_out_next = pl_rdata;
                pl_raddr    = {hit_idx_reg, 1'b1};
                state_next  = tfrc_pkg::S_PAY_WAIT;
            end
            tfrc_pkg::S_PAY_WAIT:
            begin
                if (op_reg == tfrc_pkg::OP_INSERT)
                begin
                    pl_we    = 1'b1;
                    pl_waddr = {idx_reg, 1'b1};
                    pl_wdata = lo_reg;
                    state_next = tfrc_pkg::S_OUT;
                end
                else
                begin
                    lo_out_next = pl_rdata;
                    state_next  = tfrc_pkg::S_OUT;
                end
            end
            tfrc_pkg::S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = tfrc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = tfrc_pkg::S_IDLE;
            end
        endcase

        if (drop_en)
        begin
            valid_next[drop_idx] = 1'b0;
            for (int j = 0; j < ENTRIES; j++)
            begin
                if (valid_reg[j] && rank_reg[j] > rank_reg[drop_idx])
                begin
                    rank_next[j] = rank_reg[j] - AW'(1);
                end
            end
            if (live_reg != '0)
            begin
                live_next = live_reg - CW'(1);
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        live_reg == CW'($countones(valid_reg)))
    else $error("live count disagrees with valid bits");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tfrc_pkg::S_OUT && !out_ready) |=> state_reg == tfrc_pkg::S_OUT)
    else $error("result dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> !out_valid)
    else $error("word accepted while result pending");

endmodule

[dv/ttl_fifo_record_cache_top_tb.sv]
module ttl_fifo_record_cache_top_tb;

    localparam int SLOTS = 16;

    typedef struct packed {
        logic        op;
        logic [31:0] now;
        logic [63:0] key;
        logic [15:0] rtype;
        logic [15:0] rclass;
        logic [30:0] ttl;
        logic [63:0] hi;
        logic [63:0] lo;
    } query_t;

    typedef struct packed {
        logic [2:0]  st;
        logic [30:0] ttl;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [4:0]  cnt;
    } answer_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [4:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic opcode = 1'b0;
    logic [31:0] now_seconds = '0;
    logic [63:0] name_key = '0;
    logic [15:0] record_type = '0;
    logic [15:0] record_class = '0;
    logic [30:0] ttl_in = '0;
    logic [63:0] rdata_high = '0;
    logic [63:0] rdata_low = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [2:0] status;
    logic [30:0] ttl_out;
    logic [63:0] rdata_high_out;
    logic [63:0] rdata_low_out;
    logic [4:0] entry_count;

    ttl_fifo_record_cache_top u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .opcode(opcode), .now_seconds(now_seconds), .name_key(name_key),
        .record_type(record_type), .record_class(record_class), .ttl_in(ttl_in),
        .rdata_high(rdata_high), .rdata_low(rdata_low),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .ttl_out(ttl_out), .rdata_high_out(rdata_high_out),
        .rdata_low_out(rdata_low_out), .entry_count(entry_count)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Shadow copy of the cache contents.
    logic [4:0]  cap_reg;
    logic        c_valid [SLOTS];
    logic [63:0] c_key [SLOTS];
    logic [15:0] c_type [SLOTS];
    logic [15:0] c_class [SLOTS];
    logic [30:0] c_ttl [SLOTS];
    logic [63:0] c_hi [SLOTS];
    logic [63:0] c_lo [SLOTS];
    int          c_rank [SLOTS];
    int          c_live;
    logic [31:0] c_last;

    query_t  pending_q [$];
    answer_t expected_q [$];
    int      mismatches = 0;
    bit      quiet = 1'b0;
    int      in_gap = 0;
    int      out_gap = 0;
    bit      hold_go = 1'b0;
    bit      hold_seen = 1'b0;
    int      hold_cycles = 0;
    bit      cfg_pending = 1'b0;
    logic [4:0] cfg_next;

    function automatic void drop_entry(int i);
        int r;
        r = c_rank[i];
        c_valid[i] = 1'b0;
        for (int j = 0; j < SLOTS; j++)
            if (c_valid[j] && c_rank[j] > r) c_rank[j]--;
        if (c_live > 0) c_live--;
    endfunction

    function automatic void evict_oldest();
        for (int i = 0; i < SLOTS; i++)
            if (c_valid[i] && c_rank[i] == 0)
            begin
                drop_entry(i);
                return;
            end
    endfunction

    function automatic answer_t cache_step(query_t q);
        answer_t a;
        int cap;
        int hit;
        logic [31:0] elapsed;
        a = '0;
        cap = (cap_reg < 1) ? 1 : (cap_reg > SLOTS) ? SLOTS : cap_reg;
        while (c_live > cap) evict_oldest();
        if (q.op == tfrc_pkg::OP_INSERT && q.ttl == 0)
        begin
            a.st = tfrc_pkg::ST_IGNORED;
        end
        else
        begin
            elapsed = q.now - c_last;
            for (int i = 0; i < SLOTS; i++)
                if (c_valid[i])
                begin
                    if ({1'b0, c_ttl[i]} <= elapsed) drop_entry(i);
                    else c_ttl[i] = c_ttl[i] - elapsed[30:0];
                end
            c_last = q.now;
            hit = -1;
            for (int i = 0; i < SLOTS; i++)
                if (c_valid[i] && c_key[i] == q.key && c_type[i] == q.rtype
                    && c_class[i] == q.rclass)
                    if (hit < 0 || c_rank[i] < c_rank[hit]) hit = i;
            if (q.op == tfrc_pkg::OP_LOOKUP)
            begin
                a.st = tfrc_pkg::ST_MISS;
                if (hit >= 0)
                begin
                    a.st = tfrc_pkg::ST_HIT;
                    a.ttl = c_ttl[hit];
                    a.hi = c_hi[hit];
                    a.lo = c_lo[hit];
                end
            end
            else if (hit >= 0)
            begin
                c_ttl[hit] = q.ttl;
                a.st = tfrc_pkg::ST_RENEWED;
            end
            else
            begin
                if (c_live >= cap) evict_oldest();
                for (int i = 0; i < SLOTS; i++)
                    if (!c_valid[i])
                    begin
                        c_valid[i] = 1'b1;
                        c_key[i] = q.key;
                        c_type[i] = q.rtype;
                        c_class[i] = q.rclass;
                        c_ttl[i] = q.ttl;
                        c_hi[i] = q.hi;
                        c_lo[i] = q.lo;
                        c_rank[i] = c_live;
                        c_live++;
                        break;
                    end
                a.st = tfrc_pkg::ST_STORED;
            end
        end
        a.cnt = c_live[4:0];
        return a;
    endfunction

    // Driver.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                cap_reg = cfg_data;
                cfg_valid <= 1'b0;
                cfg_pending = 1'b0;
            end
            else if (cfg_pending && !cfg_valid)
            begin
                cfg_valid <= 1'b1;
                cfg_data <= cfg_next;
            end
            if (in_valid && in_ready)
            begin
                expected_q.push_back(cache_step({opcode, now_seconds, name_key,
                    record_type, record_class, ttl_in, rdata_high, rdata_low}));
            end
            if (!in_valid || in_ready)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_q.size() > 0)
                begin
                    query_t q;
                    q = pending_q.pop_front();
                    in_valid <= 1'b1;
                    opcode <= q.op;
                    now_seconds <= q.now;
                    name_key <= q.key;
                    record_type <= q.rtype;
                    record_class <= q.rclass;
                    ttl_in <= q.ttl;
                    rdata_high <= q.hi;
                    rdata_low <= q.lo;
                    if (!quiet && $urandom_range(0, 9) == 0)
                        in_gap = $urandom_range(1, 10);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold, counted here.
    always @(posedge clk)
    begin
        if (hold_go && !hold_seen)
        begin
            hold_seen = 1'b1;
            hold_cycles = 400;
        end
        else if (hold_cycles > 0)
            hold_cycles--;
    end

    // Monitor.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: status %0d count %0d", status,
                            entry_count);
                end
                else
                begin
                    answer_t e;
                    e = expected_q.pop_front();
                    if (status !== e.st || ttl_out !== e.ttl || rdata_high_out !== e.hi
                        || rdata_low_out !== e.lo || entry_count !== e.cnt)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp %0d %h %h %h %0d got %0d %h %h %h %0d",
                                e.st, e.ttl, e.hi, e.lo, e.cnt, status, ttl_out,
                                rdata_high_out, rdata_low_out, entry_count);
                    end
                end
            end
            if (hold_cycles > 0)
            begin
                out_ready <= 1'b0;
            end
            else if (out_gap > 0)
            begin
                out_gap--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!quiet && $urandom_range(0, 9) == 0)
                    out_gap = $urandom_range(1, 10);
            end
        end
    end

    logic [31:0] clock_now = 0;
    logic [63:0] key_pool [8];

    function automatic query_t make_query(bit op, logic [30:0] ttl);
        query_t q;
        int k;
        k = $urandom_range(0, 7);
        q.op = op;
        q.now = clock_now;
        q.key = key_pool[k];
        q.rtype = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'(k % 2 + 1);
        q.rclass = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'd1;
        q.ttl = ttl;
        q.hi = {$urandom, $urandom};
        q.lo = {$urandom, $urandom};
        return q;
    endfunction

    task automatic wait_drained();
        while (pending_q.size() > 0 || in_valid || expected_q.size() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_capacity(logic [4:0] v);
        cfg_next = v;
        cfg_pending = 1'b1;
        @(posedge clk);
        while (cfg_pending) @(posedge clk);
    endtask

    initial
    begin
        query_t q;
        logic [4:0] caps [6];
        cap_reg = tfrc_pkg::CAPACITY_RESET;
        c_live = 0;
        c_last = '0;
        for (int i = 0; i < SLOTS; i++) c_valid[i] = 1'b0;
        for (int i = 0; i < 8; i++) key_pool[i] = {$urandom, $urandom};
        key_pool[0] = '0;
        key_pool[1] = '1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: extremes, zero TTL, renewal, fill past capacity,
        // a lookup after expiry, and time running backwards.
        q = make_query(tfrc_pkg::OP_INSERT, 31'h7FFFFFFF);
        q.key = '1; q.rtype = 16'hFFFF; q.rclass = 16'hFFFF; q.hi = '1; q.lo = '1;
        pending_q.push_back(q);
        q.op = tfrc_pkg::OP_LOOKUP;
        pending_q.push_back(q);
        q.op = tfrc_pkg::OP_INSERT; q.ttl = '0;
        pending_q.push_back(q);
        q.ttl = 31'd5;
        pending_q.push_back(q);
        q.op = tfrc_pkg::OP_LOOKUP;
        pending_q.push_back(q);
        for (int i = 0; i < 12; i++)
        begin
            q = make_query(tfrc_pkg::OP_INSERT, 31'(100 + i));
            q.key = 64'(i); q.rtype = '0; q.rclass = '0; q.hi = '0; q.lo = '0;
            pending_q.push_back(q);
        end
        q.op = tfrc_pkg::OP_LOOKUP; q.now = 32'd200;
        pending_q.push_back(q);
        q.now = 32'hFFFFFFF0;
        pending_q.push_back(q);
        q.now = 32'd3;
        pending_q.push_back(q);
        clock_now = 32'd3;
        wait_drained();

        caps[0] = 5'd1; caps[1] = 5'd16; caps[2] = 5'd0;
        caps[3] = 5'd31; caps[4] = 5'd4; caps[5] = 5'd10;
        for (int ph = 0; ph < 6; ph++)
        begin
            write_capacity(caps[ph]);
            if (ph == 2)
            begin
                // Receiver holds off long while items keep coming.
                hold_go = 1'b1;
            end
            if (ph == 5) quiet = 1'b1;
            for (int n = 0; n < 255; n++)
            begin
                bit op;
                logic [30:0] ttl;
                op = 1'($urandom_range(0, 1));
                case ($urandom_range(0, 9))
                    0: ttl = '0;
                    1: ttl = 31'($urandom);
                    2: ttl = 31'h7FFFFFFF;
                    default: ttl = 31'($urandom_range(1, 60));
                endcase
                case ($urandom_range(0, 19))
                    0: clock_now = $urandom;
                    1: clock_now = clock_now - $urandom_range(1, 5);
                    default: clock_now = clock_now + $urandom_range(0, 6);
                endcase
                pending_q.push_back(make_query(op, ttl));
            end
            wait_drained();
        end
        if (mismatches == 0 && expected_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #8000000;
        $display("end of test: mismatches");
        $finish;
    end
endmodule

[filelist.f]
rtl/core/tfrc_pkg.sv
rtl/core/tfrc_ram.sv
rtl/core/ttl_fifo_record_cache_top.sv
dv/ttl_fifo_record_cache_top_tb.sv
